>>> rtl/core/lbe_pkg.sv
// Shared types, key codes and operation codes for the line editor.
package lbe_pkg;

  localparam int LINE_BYTES_DEF = 256;
  localparam int QUEUE_DEPTH    = 2;

  // received byte codes
  localparam logic [7:0] CH_ESC       = 8'd27;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_UPPER_C   = 8'h43;
  localparam logic [7:0] CH_UPPER_D   = 8'h44;
  localparam logic [7:0] CH_THREE     = 8'h33;
  localparam logic [7:0] CH_TILDE     = 8'h7E;
  localparam logic [7:0] CH_RUBOUT    = 8'd127;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_KEY_DEL   = 8'd1;
  localparam logic [7:0] CH_KEY_LEFT  = 8'd2;
  localparam logic [7:0] CH_KEY_RIGHT = 8'd3;
  localparam logic [7:0] CH_PRINT_MIN = 8'h20;

  // decoded operations
  localparam logic [2:0] OP_NOP   = 3'd0;
  localparam logic [2:0] OP_INS   = 3'd1;
  localparam logic [2:0] OP_BS    = 3'd2;
  localparam logic [2:0] OP_DEL   = 3'd3;
  localparam logic [2:0] OP_LEFT  = 3'd4;
  localparam logic [2:0] OP_RIGHT = 3'd5;
  localparam logic [2:0] OP_NL    = 3'd6;
  localparam logic [2:0] OP_READ  = 3'd7;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic [7:0] ridx;
  } op_t;

  // plain key decode, no escape context
  function automatic logic [2:0] plain_op(input logic [7:0] c);
    logic [2:0] k;
    if (c == CH_BACKSPACE || c == CH_RUBOUT) begin
      k = OP_BS;
    end else if (c == CH_KEY_DEL) begin
      k = OP_DEL;
    end else if (c == CH_KEY_LEFT) begin
      k = OP_LEFT;
    end else if (c == CH_KEY_RIGHT) begin
      k = OP_RIGHT;
    end else if (c >= CH_PRINT_MIN) begin
      k = OP_INS;
    end else begin
      k = OP_NOP;
    end
    return k;
  endfunction

endpackage

>>> rtl/core/line_editor_ansi_escape.sv
// Moves, dropped bytes and reads past the end go straight to the result register; a read inside
// the line first reads the line store, an append first writes the byte, and a mid-line insert or
// a delete or backspace that shifts the tail first moves the tail bytes one place.
// The edit engine takes the next word the cycle after it loads a result, so it finishes one word
// before it takes another; the tail shift, one byte per cycle through one read and one write
// port of the line store, sets the worst case. Reset (rst_n low, synchronous) clears cursor,
// length, escape state, queue and output valid; the line store is not cleared.
module line_editor_ansi_escape import lbe_pkg::*; #(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel: received byte or read request
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_rx_byte,
  input  logic [7:0] in_read_index,
  // result channel: one word per input word
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_cursor_pos,
  output logic [7:0] out_line_length,
  output logic       out_line_done,
  output logic [7:0] out_read_char
);

  // decoder -> queue
  logic q_push, q_full;
  op_t  q_in_op;
  // queue -> edit engine
  logic q_pop, q_empty;
  op_t  q_out_op;

  // front: escape sequence decode, one word accepted per cycle while queue has room
  lbe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_rx_byte   (in_rx_byte),
    .in_read_index(in_read_index),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_op         (q_in_op)
  );

  // decoupling queue so the decoder keeps taking words while an edit shifts the tail
  lbe_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .push_op(q_in_op),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .pop_op (q_out_op)
  );

  // back: line store and edit sequencer with registered result word
  lbe_back #(
    .LINE_BYTES(LINE_BYTES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .q_op           (q_out_op),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cursor_pos (out_cursor_pos),
    .out_line_length(out_line_length),
    .out_line_done  (out_line_done),
    .out_read_char  (out_read_char)
  );

endmodule

>>> rtl/core/lbe_front.sv
// Front end: takes input words, tracks escape sequences, emits decoded ops.
module lbe_front import lbe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_rx_byte,
  input  logic [7:0] in_read_index,
  input  logic       q_full,
  output logic       q_push,
  output op_t        q_op
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ESC   = 2'd1;
  localparam logic [1:0] PH_CSI   = 2'd2;
  localparam logic [1:0] PH_CSI3  = 2'd3;

  logic [1:0] phase_r, phase_nxt;

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

  always_comb begin
    phase_nxt  = phase_r;
    q_op.ch    = in_rx_byte;
    q_op.ridx  = in_read_index;
    q_op.kind  = OP_NOP;
    if (in_mode) begin
      q_op.kind = OP_READ;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (in_rx_byte == CH_ESC) begin
            phase_nxt = PH_ESC;
          end else if (in_rx_byte == CH_NEWLINE) begin
            q_op.kind = OP_NL;
          end else begin
            q_op.kind = plain_op(in_rx_byte);
          end
        end
        PH_ESC: begin
          if (in_rx_byte == CH_LBRACKET) begin
            phase_nxt = PH_CSI;
          end else begin
            phase_nxt = PH_IDLE;
            q_op.kind = plain_op(in_rx_byte);
          end
        end
        PH_CSI: begin
          if (in_rx_byte == CH_THREE) begin
            phase_nxt = PH_CSI3;
          end else begin
            phase_nxt = PH_IDLE;
            if (in_rx_byte == CH_UPPER_C) begin
              q_op.kind = OP_RIGHT;
            end else if (in_rx_byte == CH_UPPER_D) begin
              q_op.kind = OP_LEFT;
            end else begin
              q_op.kind = plain_op(in_rx_byte);
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          if (in_rx_byte == CH_TILDE) begin
            q_op.kind = OP_DEL;
          end else begin
            q_op.kind = plain_op(in_rx_byte);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else if (q_push) begin
      phase_r <= phase_nxt;
    end
  end

endmodule

>>> rtl/core/lbe_queue.sv
// Short op queue between the decoder and the edit engine.
module lbe_queue import lbe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic empty,
  output op_t  pop_op
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  op_t           ent_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign pop_op  = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= push_op;
    end
  end

endmodule

>>> rtl/core/lbe_back.sv
// Edit engine: line store, cursor, length, tail shifting and result register.
module lbe_back import lbe_pkg::*; #(
  parameter int LINE_BYTES = LINE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  output logic       q_pop,
  input  op_t        q_op,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_cursor_pos,
  output logic [7:0] out_line_length,
  output logic       out_line_done,
  output logic [7:0] out_read_char
);

  localparam int IW = $clog2(LINE_BYTES);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP     = 3'd1;
  localparam logic [2:0] S_FIN_UP = 3'd2;
  localparam logic [2:0] S_PUT    = 3'd3;
  localparam logic [2:0] S_DN     = 3'd4;
  localparam logic [2:0] S_FIN_DN = 3'd5;
  localparam logic [2:0] S_RD     = 3'd6;
  localparam logic [2:0] S_RESULT = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [IW-1:0] cur_r, cur_nxt, len_r, len_nxt;
  logic          closed_r, closed_nxt;
  logic [IW-1:0] rptr_r, rptr_nxt, wa_r, wa_nxt;
  logic          pend_r, pend_nxt;
  logic [7:0]    ch_r, ch_nxt;
  logic          done_r, done_nxt;
  logic [7:0]    rchar_r, rchar_nxt;

  logic          ov_r, ov_nxt;
  logic [7:0]    ocur_r, olen_r, ochar_r;
  logic          odone_r;
  logic          load;

  logic [7:0]    mem [LINE_BYTES];
  logic [7:0]    mem_rd_r;
  logic          mem_we;
  logic [IW-1:0] mem_wa, mem_ra;
  logic [7:0]    mem_wd;

  logic [IW-1:0] eff_cur, eff_len;
  logic [IW+7:0] idx_ext, len_ext, cur_wide, len_wide;

  assign eff_cur = closed_r ? '0 : cur_r;
  assign eff_len = closed_r ? '0 : len_r;
  assign idx_ext = {{IW{1'b0}}, q_op.ridx};
  assign len_ext = {8'd0, len_r};
  assign q_pop   = (state_r == S_IDLE) && !q_empty;
  assign load    = (state_r == S_RESULT) && (!ov_r || !out_stall);

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    len_nxt    = len_r;
    closed_nxt = closed_r;
    rptr_nxt   = rptr_r;
    wa_nxt     = wa_r;
    pend_nxt   = pend_r;
    ch_nxt     = ch_r;
    done_nxt   = done_r;
    rchar_nxt  = rchar_r;
    mem_we     = 1'b0;
    mem_wa     = wa_r;
    mem_wd     = mem_rd_r;
    mem_ra     = rptr_r;
    unique case (state_r)
      S_IDLE: begin
        pend_nxt = 1'b0;
        if (!q_empty) begin
          state_nxt = S_RESULT;
          done_nxt  = 1'b0;
          rchar_nxt = '0;
          if (q_op.kind == OP_READ) begin
            if (idx_ext < len_ext) begin
              mem_ra    = idx_ext[IW-1:0];
              state_nxt = S_RD;
            end
          end else begin
            // a closed line is emptied by the next received byte
            closed_nxt = 1'b0;
            cur_nxt    = eff_cur;
            len_nxt    = eff_len;
            ch_nxt     = q_op.ch;
            unique case (q_op.kind)
              OP_NL: begin
                closed_nxt = 1'b1;
                done_nxt   = 1'b1;
              end
              OP_LEFT: begin
                if (eff_cur != '0) cur_nxt = eff_cur - 1'b1;
              end
              OP_RIGHT: begin
                if (eff_cur < eff_len) cur_nxt = eff_cur + 1'b1;
              end
              OP_BS: begin
                if (eff_cur != '0) begin
                  cur_nxt = eff_cur - 1'b1;
                  if (eff_cur < eff_len) begin
                    rptr_nxt  = eff_cur;
                    state_nxt = S_DN;
                  end else begin
                    len_nxt = eff_len - 1'b1;
                  end
                end
              end
              OP_DEL: begin
                if (eff_cur < eff_len) begin
                  if (eff_cur + 1'b1 < eff_len) begin
                    rptr_nxt  = eff_cur + 1'b1;
                    state_nxt = S_DN;
                  end else begin
                    len_nxt = eff_len - 1'b1;
                  end
                end
              end
              OP_INS: begin
                if (eff_len != IW'(LINE_BYTES - 1)) begin
                  if (eff_cur < eff_len) begin
                    rptr_nxt  = eff_len - 1'b1;
                    state_nxt = S_UP;
                  end else begin
                    state_nxt = S_PUT;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_UP: begin
        // read entry rptr, write the previous read one place higher
        mem_we   = pend_r;
        wa_nxt   = rptr_r + 1'b1;
        pend_nxt = 1'b1;
        if (rptr_r == cur_r) begin
          state_nxt = S_FIN_UP;
        end else begin
          rptr_nxt = rptr_r - 1'b1;
        end
      end
      S_FIN_UP: begin
        mem_we    = 1'b1;
        state_nxt = S_PUT;
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_wa    = cur_r;
        mem_wd    = ch_r;
        cur_nxt   = cur_r + 1'b1;
        len_nxt   = len_r + 1'b1;
        state_nxt = S_RESULT;
      end
      S_DN: begin
        // read entry rptr, write the previous read one place lower
        mem_we   = pend_r;
        wa_nxt   = rptr_r - 1'b1;
        pend_nxt = 1'b1;
        if (rptr_r == len_r - 1'b1) begin
          state_nxt = S_FIN_DN;
        end else begin
          rptr_nxt = rptr_r + 1'b1;
        end
      end
      S_FIN_DN: begin
        mem_we    = 1'b1;
        len_nxt   = len_r - 1'b1;
        state_nxt = S_RESULT;
      end
      S_RD: begin
        rchar_nxt = mem_rd_r;
        state_nxt = S_RESULT;
      end
      default: begin
        if (load) state_nxt = S_IDLE;
      end
    endcase
  end

  assign ov_nxt = (ov_r && out_stall) || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cur_r    <= '0;
      len_r    <= '0;
      closed_r <= 1'b0;
      pend_r   <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cur_r    <= cur_nxt;
      len_r    <= len_nxt;
      closed_r <= closed_nxt;
      pend_r   <= pend_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rptr_r  <= rptr_nxt;
    wa_r    <= wa_nxt;
    ch_r    <= ch_nxt;
    done_r  <= done_nxt;
    rchar_r <= rchar_nxt;
  end

  assign cur_wide = {8'd0, cur_r};
  assign len_wide = {8'd0, len_r};

  always_ff @(posedge clk) begin
    if (load) begin
      ocur_r  <= cur_wide[7:0];
      olen_r  <= len_wide[7:0];
      odone_r <= done_r;
      ochar_r <= rchar_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_r <= mem[mem_ra];
  end

  assign out_valid       = ov_r;
  assign out_cursor_pos  = ocur_r;
  assign out_line_length = olen_r;
  assign out_line_done   = odone_r;
  assign out_read_char   = ochar_r;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the line editor with ANSI cursor keys.
module testbench;
  import lbe_pkg::*;

  localparam int LINE_BYTES = LINE_BYTES_DEF;
  localparam int TOTAL_WORDS = 500;

  // escape decoder state as the predictor tracks it
  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_SEEN,
    ESC_BRACKET,
    ESC_THREE
  } esc_phase_t;

  // one result word, field for field as on the out_ ports
  typedef struct packed {
    logic [7:0] cursor_pos;
    logic [7:0] line_length;
    logic       line_done;
    logic [7:0] read_char;
  } editor_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_mode = 1'b0;
  logic [7:0] in_rx_byte = 8'd0;
  logic [7:0] in_read_index = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_cursor_pos;
  logic [7:0] out_line_length;
  logic       out_line_done;
  logic [7:0] out_read_char;

  // predictor state: line bytes, cursor, length, escape phase, closed flag
  logic [7:0] m_line [LINE_BYTES];
  int         m_cursor;
  int         m_length;
  esc_phase_t m_esc;
  bit         m_closed;

  editor_result_t expected_results [$];
  bit failed = 1'b0;
  bit idle_on = 1'b1;   // random gaps on both sides when set
  bit rx_hold = 1'b0;   // long receiver hold-off
  int stall_left = 0;
  int sent_words = 0;   // input words accepted so far

  line_editor_ansi_escape #(
    .LINE_BYTES(LINE_BYTES)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_rx_byte     (in_rx_byte),
    .in_read_index  (in_read_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cursor_pos (out_cursor_pos),
    .out_line_length(out_line_length),
    .out_line_done  (out_line_done),
    .out_read_char  (out_read_char)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // remove the byte at pos, tail moves one place left
  function automatic void drop_byte(input int pos);
    int i;
    for (i = pos; i + 1 < m_length; i++) m_line[i] = m_line[i + 1];
    m_length--;
  endfunction

  // a decoded key or plain byte, no escape context left
  function automatic void apply_key(input logic [7:0] c);
    int i;
    if (c == CH_BACKSPACE || c == CH_RUBOUT) begin
      if (m_cursor > 0) begin
        m_cursor--;
        drop_byte(m_cursor);
      end
    end else if (c == CH_KEY_DEL) begin
      if (m_cursor < m_length) drop_byte(m_cursor);
    end else if (c == CH_KEY_LEFT) begin
      if (m_cursor > 0) m_cursor--;
    end else if (c == CH_KEY_RIGHT) begin
      if (m_cursor < m_length) m_cursor++;
    end else if (c >= CH_PRINT_MIN) begin
      // full line: printable bytes are dropped
      if (m_length < LINE_BYTES - 1) begin
        for (i = m_length; i > m_cursor; i--) m_line[i] = m_line[i - 1];
        m_line[m_cursor] = c;
        m_cursor++;
        m_length++;
      end
    end
    // remaining control bytes fall through and are dropped
  endfunction

  // advance the predictor by one accepted word, return the result it owes
  function automatic editor_result_t apply_word(input logic m, input logic [7:0] b,
                                                input logic [7:0] idx);
    editor_result_t r;
    r = '0;
    if (m) begin
      // read leaves every bit of state alone
      if (idx < m_length) r.read_char = m_line[idx];
    end else begin
      // first edit word after newline starts an empty line
      if (m_closed) begin
        m_cursor = 0;
        m_length = 0;
        m_closed = 1'b0;
      end
      case (m_esc)
        ESC_IDLE: begin
          if (b == CH_ESC) begin
            m_esc = ESC_SEEN;
          end else if (b == CH_NEWLINE) begin
            m_closed = 1'b1;
            r.line_done = 1'b1;
          end else begin
            apply_key(b);
          end
        end
        ESC_SEEN: begin
          if (b == CH_LBRACKET) begin
            m_esc = ESC_BRACKET;
          end else begin
            m_esc = ESC_IDLE;
            apply_key(b);
          end
        end
        ESC_BRACKET: begin
          if (b == CH_THREE) begin
            m_esc = ESC_THREE;
          end else begin
            m_esc = ESC_IDLE;
            if (b == CH_UPPER_C) apply_key(CH_KEY_RIGHT);
            else if (b == CH_UPPER_D) apply_key(CH_KEY_LEFT);
            else apply_key(b);
          end
        end
        default: begin
          m_esc = ESC_IDLE;
          apply_key((b == CH_TILDE) ? CH_KEY_DEL : b);
        end
      endcase
    end
    r.cursor_pos  = m_cursor[7:0];
    r.line_length = m_length[7:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // Offer one word, hold it until accepted, then log what it should produce.
  // Runs only from posedge steps, so in_valid gets one assignment per step.
  task automatic send_word(input logic m, input logic [7:0] b, input logic [7:0] idx);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= m;
    in_rx_byte    <= b;
    in_read_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(apply_word(m, b, idx));
    sent_words++;
  endtask

  // edit word; read_index is don't-care, randomized so its bits move
  task automatic send_byte(input logic [7:0] b);
    send_word(1'b0, b, 8'($urandom_range(0, 255)));
  endtask

  // read word; rx_byte is don't-care
  task automatic send_read(input logic [7:0] idx);
    send_word(1'b1, 8'($urandom_range(0, 255)), idx);
  endtask

  // ESC [ then the given byte
  task automatic send_csi(input logic [7:0] key_ch);
    send_byte(CH_ESC);
    send_byte(CH_LBRACKET);
    send_byte(key_ch);
  endtask

  // stop offering and wait until every pending result has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // any printable byte, low and high range, never rubout
  function automatic logic [7:0] pick_printable();
    logic [7:0] v;
    v = 8'($urandom_range(32, 254));
    if (v == CH_RUBOUT) v = 8'hFF;
    return v;
  endfunction

  // ---------------------------------------------------------------------
  // Receiver side: random stall per result word, plus the long hold-off
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : result_stall
    int n;
    if (rx_hold) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (out_valid && !out_stall) begin
      // word taken at this edge: draw the wait before the next one
      n = idle_on ? $urandom_range(0, 5) : 0;
      out_stall <= (n != 0);
      stall_left <= (n != 0) ? n - 1 : 0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare every accepted result word with the oldest expectation
  always @(posedge clk) begin : result_check
    editor_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("result word with no expectation pending");
        failed = 1'b1;
      end else begin
        want = expected_results.pop_front();
        if (out_cursor_pos !== want.cursor_pos) begin
          $error("cursor_pos: expected %0d, actual %0d", want.cursor_pos, out_cursor_pos);
          failed = 1'b1;
        end
        if (out_line_length !== want.line_length) begin
          $error("line_length: expected %0d, actual %0d", want.line_length,
                 out_line_length);
          failed = 1'b1;
        end
        if (out_line_done !== want.line_done) begin
          $error("line_done: expected %0d, actual %0d", want.line_done, out_line_done);
          failed = 1'b1;
        end
        if (out_read_char !== want.read_char) begin
          $error("read_char: expected 0x%02h, actual 0x%02h", want.read_char,
                 out_read_char);
          failed = 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // empty line after reset: reads at both ends return zero
  task automatic test_reset_reads();
    send_read(8'd0);
    send_read(8'd255);
    wait_results_drained();
  endtask

  // byte range edges: lowest and highest printable on both sides of rubout
  task automatic test_insert_extremes();
    send_byte(8'h20);
    send_byte(8'h7E);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_read(8'd0);
    send_read(8'd3);
    send_read(8'd4);   // just past the end
    wait_results_drained();
  endtask

  // arrows, delete and backspace in both encodings, and the edges
  task automatic test_cursor_keys();
    send_csi(CH_UPPER_D);          // left
    send_csi(CH_UPPER_D);
    send_csi(CH_UPPER_C);          // right
    send_byte(CH_KEY_LEFT);
    send_byte(8'h41);              // insert mid-line
    send_csi(CH_THREE);
    send_byte(CH_TILDE);           // delete at cursor
    send_byte(CH_KEY_DEL);
    send_byte(CH_BACKSPACE);
    send_byte(CH_RUBOUT);
    send_read(8'd0);
    // far left: left and backspace do nothing
    repeat (4) send_byte(CH_KEY_LEFT);
    send_byte(CH_BACKSPACE);
    // far right: right and delete do nothing
    repeat (4) send_byte(CH_KEY_RIGHT);
    send_csi(CH_UPPER_C);
    send_byte(CH_KEY_DEL);
    wait_results_drained();
  endtask

  // sequences cut short, stray controls, ESC and newline inside a sequence
  task automatic test_broken_escapes();
    send_byte(CH_ESC);
    send_byte(8'h78);              // ESC x: x inserted
    send_byte(CH_ESC);
    send_byte(CH_LBRACKET);
    send_byte(CH_KEY_LEFT);        // ESC [ ^B: still a left key
    send_csi(CH_THREE);
    send_byte(8'h7A);              // ESC [ 3 z: z inserted
    send_byte(CH_ESC);
    send_byte(CH_ESC);             // second ESC is dropped, no new sequence
    send_byte(CH_LBRACKET);        // so this is a plain '['
    send_byte(CH_ESC);
    send_byte(CH_NEWLINE);         // dropped, line stays open
    send_csi(CH_NEWLINE);
    send_csi(CH_THREE);
    send_byte(CH_ESC);
    send_byte(8'h00);
    send_byte(8'h1F);
    send_byte(8'h09);
    send_byte(8'h0D);
    wait_results_drained();
  endtask

  // newline closes, reads keep the old line, next edit word starts fresh
  task automatic test_newline();
    send_byte(8'h61);
    send_byte(CH_NEWLINE);
    send_read(8'd0);
    send_read(8'd1);
    send_byte(8'h62);
    send_byte(CH_NEWLINE);
    send_byte(CH_NEWLINE);         // empty line closes too
    send_byte(CH_KEY_LEFT);        // edit word on a closed line: clears first
    wait_results_drained();
  endtask

  // fill to LINE_BYTES - 1, then poke at the limit
  task automatic test_full_line();
    send_byte(CH_NEWLINE);
    repeat (LINE_BYTES - 1) send_byte(pick_printable());
    send_byte(8'h51);              // ignored, line full
    send_csi(CH_UPPER_D);
    send_byte(8'h52);              // ignored mid-line too
    send_read(8'(LINE_BYTES - 2));
    send_read(8'(LINE_BYTES - 1));
    send_byte(CH_BACKSPACE);
    send_byte(8'h53);              // fits again, shifts the last byte up
    send_byte(CH_KEY_RIGHT);
    send_byte(CH_KEY_DEL);         // at the end: nothing
    repeat (4) send_read(8'($urandom_range(0, 255)));
    send_byte(CH_NEWLINE);
    wait_results_drained();
  endtask

  // receiver holds off for a long stretch while the sender keeps pushing,
  // so the block fills and stalls its input; then the sender waits it out
  task automatic test_backpressure();
    idle_on = 1'b0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (300) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    repeat (6) send_byte(pick_printable());
    send_csi(CH_UPPER_D);
    send_byte(8'h30);
    repeat (4) send_read(8'($urandom_range(0, 8)));
    send_byte(CH_RUBOUT);
    send_byte(CH_NEWLINE);
    wait_results_drained();
    idle_on = 1'b1;
  endtask

  // mostly well-formed editing traffic with random content, some noise,
  // until the run has sent its share of input words
  task automatic test_random_editing();
    int pick;
    int n;
    while (sent_words < TOTAL_WORDS) begin
      // switch idling on and off so there are also stretches without gaps
      if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_byte(pick_printable());
      end else if (pick < 45) begin
        send_csi($urandom_range(0, 1) ? CH_UPPER_C : CH_UPPER_D);
      end else if (pick < 50) begin
        send_csi(CH_THREE);
        send_byte(CH_TILDE);
      end else if (pick < 60) begin
        case ($urandom_range(0, 4))
          0: send_byte(CH_KEY_DEL);
          1: send_byte(CH_KEY_LEFT);
          2: send_byte(CH_KEY_RIGHT);
          3: send_byte(CH_BACKSPACE);
          default: send_byte(CH_RUBOUT);
        endcase
      end else if (pick < 63) begin
        send_byte(CH_NEWLINE);
      end else if (pick < 80) begin
        // half the reads land inside the line
        if (m_length != 0 && $urandom_range(0, 1) != 0) begin
          send_read(8'($urandom_range(0, m_length - 1)));
        end else begin
          send_read(8'($urandom_range(0, 255)));
        end
      end else if (pick < 90) begin
        // escape cut after a random prefix by any byte
        send_byte(CH_ESC);
        n = $urandom_range(0, 2);
        if (n > 0) send_byte(CH_LBRACKET);
        if (n > 1) send_byte(CH_THREE);
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        // raw noise, often a dropped control
        send_byte(8'($urandom_range(0, 255)));
      end
    end
    wait_results_drained();
    idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // Run
  // ---------------------------------------------------------------------
  initial begin
    m_cursor = 0;
    m_length = 0;
    m_esc    = ESC_IDLE;
    m_closed = 1'b0;
    foreach (m_line[i]) m_line[i] = 8'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_reads();
    test_insert_extremes();
    test_cursor_keys();
    test_broken_escapes();
    test_newline();
    test_full_line();
    test_backpressure();
    test_random_editing();

    // let any late or extra word show up before deciding
    repeat (LINE_BYTES + 8) @(posedge clk);
    if (failed || expected_results.size() != 0) begin
      $display("status: fail");
    end else begin
      $display("status: pass");
    end
    $finish;
  end

  // hard stop far beyond the slowest correct run
  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/lbe_pkg.sv
rtl/core/lbe_front.sv
rtl/core/lbe_queue.sv
rtl/core/lbe_back.sv
rtl/core/line_editor_ansi_escape.sv
tb/testbench.sv
